// ===== design/chkr_pkg.sv =====
// ----------------------------------------------------------------------------
// chkr_pkg
// Types, widths and helpers shared by the keyframe resampler modules.
// ----------------------------------------------------------------------------
package chkr_pkg;

    // sample index stays below 2^26: (key + 1) * rate < 2^42
    localparam int IDX_W = 26;
    localparam int LIM_W = 43;
    localparam int RATE_W = 10;
    localparam logic [RATE_W-1:0] DEFAULT_RATE = 10'd30;
    localparam logic [18:0] T_MIN_MAG = 19'd262144;

    typedef struct packed {
        logic [31:0] key_time;
        logic [63:0] in_tangent_vec;
        logic [63:0] value_vec;
        logic [63:0] out_tangent_vec;
        logic        is_last_key;
    } in_item_t;

    typedef struct packed {
        logic [31:0] sample_time;
        logic [63:0] sample_vec;
        logic        last_of_run;
        logic        segment_truncated;
    } out_item_t;

    // queued key with what the front found out about it
    typedef struct packed {
        in_item_t    item;
        logic [31:0] prev_time;
        logic        seg;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic signed [15:0] lane16(input logic [63:0] v, input logic [1:0] i);
        lane16 = v[{i, 4'b0000} +: 16];
    endfunction

endpackage

// ===== design/chkr_front.sv =====
// ----------------------------------------------------------------------------
// chkr_front
// Accepts keyframes and tags each one as opening a segment or not.
// ----------------------------------------------------------------------------
module chkr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  chkr_pkg::in_item_t s_item,
    input  chkr_pkg::q_status_t q_status,
    output logic              push_valid,
    output chkr_pkg::cmd_t    push_cmd
);
    import chkr_pkg::*;

    logic [31:0] prev_time_reg;
    logic        have_prev_reg;

    assign s_ready    = !q_status.full;
    assign push_valid = s_valid && !q_status.full;

    always_comb begin
        push_cmd.item      = s_item;
        push_cmd.prev_time = prev_time_reg;
        push_cmd.seg       = have_prev_reg && (s_item.key_time > prev_time_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg <= '0;
            have_prev_reg <= 1'b0;
        end else if (push_valid) begin
            // last key restarts the channel
            prev_time_reg <= s_item.is_last_key ? 32'd0 : s_item.key_time;
            have_prev_reg <= !s_item.is_last_key;
        end
    end

endmodule

// ===== design/chkr_queue.sv =====
// ----------------------------------------------------------------------------
// chkr_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module chkr_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  chkr_pkg::cmd_t     push_cmd,
    input  logic               pop,
    output chkr_pkg::cmd_t     head,
    output chkr_pkg::q_status_t status
);
    import chkr_pkg::*;

    cmd_t       data_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign head         = data_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/chkr_back.sv =====
// ----------------------------------------------------------------------------
// chkr_back
// Runs one queued key; for a key that opens a segment: tangent scaling, then per
// sample two bit-serial divisions and a shared multiply-accumulate over the lanes.
// ----------------------------------------------------------------------------
module chkr_back #(
    parameter int LANES = 4,
    parameter int MAX_SAMPLES_PER_SEGMENT = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [9:0]           sample_rate,
    input  chkr_pkg::cmd_t       cmd,
    input  chkr_pkg::q_status_t  q_status,
    output logic                 cmd_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output chkr_pkg::out_item_t  m_item
);
    import chkr_pkg::*;

    localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int NW = $clog2(MAX_SAMPLES_PER_SEGMENT + 1);
    localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(LANES - 1);
    localparam logic [NW-1:0] N_LAST = NW'(MAX_SAMPLES_PER_SEGMENT - 1);
    localparam logic [IDX_W:0] MAX_ADD = (IDX_W + 1)'(MAX_SAMPLES_PER_SEGMENT);

    typedef enum logic [3:0] {
        S_IDLE, S_LIM, S_TAN_MUL, S_TAN_ACC, S_CHK, S_DTS, S_DIFF, S_DT,
        S_T0, S_T2, S_T3, S_BASIS, S_LN_MUL, S_LN_ACC, S_EMIT, S_FIN
    } state_t;

    state_t              state_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [63:0]         prev_val_reg;
    logic [63:0]         prev_tout_reg;
    logic [LIM_W-1:0]    lim_reg;
    logic [31:0]         dt_reg;
    logic                trunc_reg;
    logic [32:0]         m0_reg [LANES];
    logic [32:0]         m1_reg [LANES];
    logic [LANE_W-1:0]   lane_reg;
    logic [2:0]          sub_reg;
    logic signed [59:0]  acc_reg;
    logic signed [46:0]  prod_reg;
    logic [9:0]          rem_ts_reg;
    logic [31:0]         qts_reg;
    logic [4:0]          cnt_reg;
    logic                neg_reg;
    logic                big_reg;
    logic [31:0]         remt_reg;
    logic [18:0]         qt_reg;
    logic signed [19:0]  t_reg;
    logic signed [21:0]  t2_reg;
    logic signed [25:0]  ba_reg, bb_reg, bc_reg, be_reg;
    logic [63:0]         vec_reg;
    logic [NW-1:0]       n_reg;
    logic                m_valid_reg;
    out_item_t           m_item_reg;

    logic [9:0]          rate_eff;
    logic signed [25:0]  mul_a;
    logic signed [20:0]  mul_b;
    logic                hi_shift;
    logic signed [59:0]  prod_ext;
    logic signed [59:0]  accsum;
    logic signed [59:0]  rsum;
    logic [15:0]         sat_lane;
    logic [32:0]         m0_cur, m1_cur;
    logic [15:0]         lane_a;
    logic [10:0]         ts_r2;
    logic                ts_ge;
    logic [32:0]         t_r2;
    logic                t_ge;
    logic [31:0]         absd;
    logic                neg_now;
    logic [IDX_W:0]      idx_inc;
    logic [IDX_W:0]      idx_max;
    logic [LIM_W-1:0]    lim_up;
    logic                last_now;
    logic [18:0]         mag;
    logic signed [25:0]  x2, x3, xt;
    logic signed [23:0]  t3_now;
    logic                emit_fire;

    assign rate_eff  = (sample_rate == 10'd0) ? DEFAULT_RATE : sample_rate;
    assign cmd_pop   = (state_reg == S_FIN);
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;
    assign emit_fire = (state_reg == S_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        m0_cur = m0_reg[lane_reg];
        m1_cur = m1_reg[lane_reg];
        lane_a = sub_reg[1] ? lane16(cmd.item.in_tangent_vec, 2'(lane_reg))
                            : lane16(prev_tout_reg, 2'(lane_reg));
        mul_a    = '0;
        mul_b    = '0;
        hi_shift = 1'b0;
        unique case (state_reg)
            S_TAN_MUL, S_TAN_ACC: begin
                mul_a    = {{10{lane_a[15]}}, lane_a};
                mul_b    = sub_reg[0] ? {5'b0, dt_reg[15:0]} : {5'b0, dt_reg[31:16]};
                hi_shift = !sub_reg[0];
            end
            S_T2: begin
                mul_a = {{6{t_reg[19]}}, t_reg};
                mul_b = {t_reg[19], t_reg};
            end
            S_T3: begin
                mul_a = {4'b0, prod_reg[37:16]};
                mul_b = {t_reg[19], t_reg};
            end
            S_LN_MUL, S_LN_ACC: begin
                case (sub_reg)
                    3'd0: begin
                        mul_a = ba_reg;
                        mul_b = {{5{prev_val_reg[{2'(lane_reg), 4'b1111}]}},
                                 lane16(prev_val_reg, 2'(lane_reg))};
                    end
                    3'd1: begin
                        mul_a    = bb_reg;
                        mul_b    = {{4{m0_cur[32]}}, m0_cur[32:16]};
                        hi_shift = 1'b1;
                    end
                    3'd2: begin
                        mul_a = bb_reg;
                        mul_b = {5'b0, m0_cur[15:0]};
                    end
                    3'd3: begin
                        mul_a = bc_reg;
                        mul_b = {{5{cmd.item.value_vec[{2'(lane_reg), 4'b1111}]}},
                                 lane16(cmd.item.value_vec, 2'(lane_reg))};
                    end
                    3'd4: begin
                        mul_a    = be_reg;
                        mul_b    = {{4{m1_cur[32]}}, m1_cur[32:16]};
                        hi_shift = 1'b1;
                    end
                    default: begin
                        mul_a = be_reg;
                        mul_b = {5'b0, m1_cur[15:0]};
                    end
                endcase
            end
            default: begin
                mul_a = '0;
            end
        endcase

        prod_ext = 60'(prod_reg);
        accsum   = acc_reg + (hi_shift ? (prod_ext <<< 16) : prod_ext);
        rsum     = (accsum + 60'sd32768) >>> 16;
        if (rsum > 60'sd32767) begin
            sat_lane = 16'h7fff;
        end else if (rsum < -60'sd32768) begin
            sat_lane = 16'h8000;
        end else begin
            sat_lane = rsum[15:0];
        end

        ts_r2 = {rem_ts_reg, qts_reg[31]};
        ts_ge = (ts_r2 >= {1'b0, rate_eff});
        t_r2  = {remt_reg, qt_reg[18]};
        t_ge  = (t_r2 >= {1'b0, dt_reg});

        neg_now = (qts_reg < cmd.prev_time);
        absd    = neg_now ? (cmd.prev_time - qts_reg) : (qts_reg - cmd.prev_time);

        idx_inc  = {1'b0, idx_reg} + {{IDX_W{1'b0}}, 1'b1};
        idx_max  = {1'b0, idx_reg} + MAX_ADD;
        lim_up   = lim_reg + LIM_W'(65535);
        last_now = (n_reg == N_LAST) || ({idx_inc, 16'b0} >= lim_reg);

        mag = (big_reg || (qt_reg > T_MIN_MAG)) ? T_MIN_MAG : qt_reg;

        t3_now = prod_reg[39:16];
        x2 = 26'(t2_reg);
        x3 = 26'(t3_now);
        xt = 26'(t_reg);
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            prev_val_reg  <= '0;
            prev_tout_reg <= '0;
            m_valid_reg   <= 1'b0;
            trunc_reg     <= 1'b0;
        end else begin
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!q_status.empty) begin
                        state_reg <= cmd.seg ? S_LIM : S_FIN;
                        trunc_reg <= 1'b0;
                    end
                end
                S_LIM: begin
                    lim_reg   <= LIM_W'(({1'b0, cmd.item.key_time} + 33'd1) * rate_eff);
                    dt_reg    <= cmd.item.key_time - cmd.prev_time;
                    acc_reg   <= '0;
                    lane_reg  <= '0;
                    sub_reg   <= '0;
                    state_reg <= S_TAN_MUL;
                end
                S_TAN_MUL: begin
                    state_reg <= S_TAN_ACC;
                end
                S_TAN_ACC: begin
                    // odd steps close a tangent: m = floor(lane * dt / 2^16)
                    if (sub_reg[0]) begin
                        acc_reg <= '0;
                        if (sub_reg[1]) begin
                            m1_reg[lane_reg] <= accsum[48:16];
                        end else begin
                            m0_reg[lane_reg] <= accsum[48:16];
                        end
                    end else begin
                        acc_reg <= accsum;
                    end
                    state_reg <= S_TAN_MUL;
                    if (sub_reg == 3'd3) begin
                        sub_reg <= '0;
                        if (lane_reg == LANE_LAST) begin
                            state_reg <= S_CHK;
                        end else begin
                            lane_reg <= lane_reg + 1'b1;
                        end
                    end else begin
                        sub_reg <= sub_reg + 3'd1;
                    end
                end
                S_CHK: begin
                    n_reg <= '0;
                    if ({1'b0, idx_reg, 16'b0} < lim_reg) begin
                        trunc_reg  <= ({idx_max, 16'b0} < lim_reg);
                        rem_ts_reg <= idx_reg[25:16];
                        qts_reg    <= {idx_reg[15:0], 16'b0};
                        cnt_reg    <= '0;
                        state_reg  <= S_DTS;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_DTS: begin
                    // sample time = (index << 16) / rate, one bit per cycle
                    rem_ts_reg <= ts_ge ? 10'(ts_r2 - {1'b0, rate_eff}) : ts_r2[9:0];
                    qts_reg    <= {qts_reg[30:0], ts_ge};
                    cnt_reg    <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    neg_reg   <= neg_now;
                    big_reg   <= ({3'b0, absd} >= {dt_reg, 3'b0});
                    remt_reg  <= {3'b0, absd[31:3]};
                    qt_reg    <= {absd[2:0], 16'b0};
                    cnt_reg   <= '0;
                    state_reg <= S_DT;
                end
                S_DT: begin
                    // segment position |d| * 2^16 / dt, 19 quotient bits
                    remt_reg <= t_ge ? 32'(t_r2 - {1'b0, dt_reg}) : t_r2[31:0];
                    qt_reg   <= {qt_reg[17:0], t_ge};
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd18) begin
                        state_reg <= S_T0;
                    end
                end
                S_T0: begin
                    t_reg     <= neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                    state_reg <= S_T2;
                end
                S_T2: begin
                    state_reg <= S_T3;
                end
                S_T3: begin
                    t2_reg    <= prod_reg[37:16];
                    state_reg <= S_BASIS;
                end
                S_BASIS: begin
                    ba_reg    <= (x3 <<< 1) - (x2 + (x2 <<< 1)) + 26'sd65536;
                    bb_reg    <= x3 - (x2 <<< 1) + xt;
                    bc_reg    <= (x2 + (x2 <<< 1)) - (x3 <<< 1);
                    be_reg    <= x3 - x2;
                    vec_reg   <= '0;
                    acc_reg   <= '0;
                    lane_reg  <= '0;
                    sub_reg   <= '0;
                    state_reg <= S_LN_MUL;
                end
                S_LN_MUL: begin
                    state_reg <= S_LN_ACC;
                end
                S_LN_ACC: begin
                    state_reg <= S_LN_MUL;
                    if (sub_reg == 3'd5) begin
                        acc_reg <= '0;
                        vec_reg[{2'(lane_reg), 4'b0000} +: 16] <= sat_lane;
                        sub_reg <= '0;
                        if (lane_reg == LANE_LAST) begin
                            state_reg <= S_EMIT;
                        end else begin
                            lane_reg <= lane_reg + 1'b1;
                        end
                    end else begin
                        acc_reg <= accsum;
                        sub_reg <= sub_reg + 3'd1;
                    end
                end
                S_EMIT: begin
                    if (emit_fire) begin
                        m_item_reg.sample_time         <= qts_reg;
                        m_item_reg.sample_vec          <= vec_reg;
                        m_item_reg.last_of_run         <= last_now;
                        m_item_reg.segment_truncated   <= trunc_reg;
                        idx_reg                        <= idx_inc[IDX_W-1:0];
                        n_reg                          <= n_reg + 1'b1;
                        if (last_now) begin
                            state_reg <= S_FIN;
                        end else begin
                            rem_ts_reg <= idx_inc[25:16];
                            qts_reg    <= {idx_inc[15:0], 16'b0};
                            cnt_reg    <= '0;
                            state_reg  <= S_DTS;
                        end
                    end
                end
                S_FIN: begin
                    if (cmd.item.is_last_key) begin
                        idx_reg <= '0;
                    end else if (trunc_reg) begin
                        // skipped samples: jump past the key's time
                        idx_reg <= lim_up[41:16];
                    end
                    prev_val_reg  <= cmd.item.value_vec;
                    prev_tout_reg <= cmd.item.out_tangent_vec;
                    state_reg     <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/cubic_hermite_keyframe_resampler.sv =====
// ----------------------------------------------------------------------------
// cubic_hermite_keyframe_resampler
// Resamples a cubic Hermite keyframe channel at uniform sample times.
// ----------------------------------------------------------------------------
// Keys are accepted into a two-entry queue and worked off one at a time by a
// sequencer with one shared multiplier and two bit-serial dividers. A key that
// opens no segment only passes from idle to the finish state. A key that opens
// a segment first has its tangents scaled (setup), then for each sample runs
// the sample-time division (32 quotient bits), the segment-position division
// (19 quotient bits) and a multiply and an accumulate step per term over six
// terms per lane. Results sit in an output register, so the next sample is
// computed while one waits to be taken.
// sample_rate is written through cfg_wr_en/cfg_wr_data; zero means 30.
// ----------------------------------------------------------------------------
module cubic_hermite_keyframe_resampler #(
    parameter int LANES = 4,
    parameter int MAX_SAMPLES_PER_SEGMENT = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [9:0]          cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  chkr_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output chkr_pkg::out_item_t m_item
);
    import chkr_pkg::*;

    logic [RATE_W-1:0] sample_rate_reg;
    logic              push_valid;
    cmd_t              push_cmd;
    cmd_t              head;
    q_status_t         q_status;
    logic              pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_rate_reg <= DEFAULT_RATE;
        end else if (cfg_wr_en) begin
            sample_rate_reg <= cfg_wr_data;
        end
    end

    chkr_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .q_status   (q_status),
        .push_valid (push_valid),
        .push_cmd   (push_cmd)
    );

    chkr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    chkr_back #(
        .LANES                   (LANES),
        .MAX_SAMPLES_PER_SEGMENT (MAX_SAMPLES_PER_SEGMENT)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sample_rate (sample_rate_reg),
        .cmd         (head),
        .q_status    (q_status),
        .cmd_pop     (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

// ===== design/chkr_checker.sv =====
// ----------------------------------------------------------------------------
// chkr_checker
// Port-level checks on the keyframe resampler, bound to the top level.
// ----------------------------------------------------------------------------
module chkr_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input chkr_pkg::out_item_t m_item
);
    import chkr_pkg::*;

    // nothing is pending after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // queue is empty after reset so a key can be taken at once
    assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result transaction withdrawn");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_item))
        else $error("result payload changed while stalled");

endmodule

bind cubic_hermite_keyframe_resampler chkr_checker u_chkr_checker (.*);
